// ===== hdl/sft_pkg.sv =====
// Shared types and constants of the scaled frame timer.
// No dependencies; used by sft_div and scaled_frame_timer_core.
`default_nettype none

package sft_pkg;

  // Fixed field widths
  localparam int TS_W   = 64;  // timestamp and tick counts
  localparam int TF_W   = 32;  // tick_frequency
  localparam int FFR_W  = 10;  // fixed_frame_rate
  localparam int PR_W   = 23;  // play_rate
  localparam int OP_W   = 2;   // opcode
  localparam int FX_W   = 32;  // fixed point results, divider quotient
  localparam int CFG_W  = 32;  // config write data
  localparam int IDX_W  = 2;   // config register index
  localparam int MCNT_W = $clog2(PR_W);
  localparam int QCNT_W = $clog2(FX_W);

  // Opcodes
  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
  localparam logic [OP_W-1:0] OP_PAUSE   = 2'd2;
  localparam logic [OP_W-1:0] OP_RESUME  = 2'd3;

  // Config register indexes
  localparam logic [IDX_W-1:0] REG_TICK_FREQ  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FIXED_MODE = 2'd1;
  localparam logic [IDX_W-1:0] REG_FIXED_RATE = 2'd2;
  localparam logic [IDX_W-1:0] REG_PLAY_RATE  = 2'd3;

  // Config reset values that do not follow the fraction width
  localparam logic [TF_W-1:0]  TICK_FREQ_RESET  = 32'd1000000;
  localparam logic [FFR_W-1:0] FIXED_RATE_RESET = 10'd60;

  // Divider control
  typedef struct packed {
    logic start;  // load operands this cycle
    logic frac;   // numerator carries FRAC_BITS fraction bits
  } div_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/sft_div.sv =====
// Bit-serial saturating divider: quo = min(floor(num * 2^s / den), 2^32-1), s = 0 or FRAC_BITS.
// One quotient bit per cycle. Depends on sft_pkg.
`default_nettype none

module sft_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  sft_pkg::div_ctl_t            ctl_i,
  input  wire [sft_pkg::TS_W-1:0]      num_i,
  input  wire [sft_pkg::TS_W-1:0]      den_i,
  output logic                         done_o,
  output logic [sft_pkg::FX_W-1:0]     quo_o
);

  localparam int TW = sft_pkg::TS_W;
  localparam int QW = sft_pkg::FX_W;
  localparam int CW = TW + QW;
  localparam logic [sft_pkg::QCNT_W-1:0] CNT_LAST = sft_pkg::QCNT_W'(QW - 1);

  logic [CW-1:0] num_ext;
  logic          sat;
  logic [TW-1:0] rem_q, rem_d;
  logic [TW-1:0] den_q;
  logic [QW-1:0] low_q, low_d;
  logic [TW:0]   trial, diff;
  logic          fits;
  logic [sft_pkg::QCNT_W-1:0] cnt_q;
  logic          busy_q, done_q;

  assign num_ext = ctl_i.frac ? ({{QW{1'b0}}, num_i} << FRAC_BITS) : {{QW{1'b0}}, num_i};

  // Quotient needs more than 32 bits exactly when num_ext >= den * 2^32.
  assign sat = (den_i == '0) || (num_ext >= {den_i, {QW{1'b0}}});

  // Partial remainder stays below den, so one extra bit covers the shift.
  assign trial = {rem_q, low_q[QW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};
  assign rem_d = fits ? diff[TW-1:0] : trial[TW-1:0];
  assign low_d = {low_q[QW-2:0], fits};

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      den_q <= den_i;
      rem_q <= num_ext[CW-1:QW];
      low_q <= sat ? '1 : num_ext[QW-1:0];
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= !sat;
        done_q <= sat;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = low_q;

endmodule

`default_nettype wire

// ===== hdl/scaled_frame_timer_core.sv =====
// Scaled frame timer: scaled time accumulator with moving averages of delta and frame rate.
// Depends on sft_pkg and sft_div.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one beat per frame event:
//   opcode_i (tick, restart, pause, resume) and the timestamp_i counter value.
//   Every accepted beat yields exactly one result beat on the output channel
//   (out_valid_o / out_stall_i) reporting the timer state after that beat.
//   One item is processed at a time; in_stall_o is high while an item works.
//   Restart, pause, resume and ticks while paused go from idle straight to the
//   finish state and then into the output register. A running tick mostly
//   waits on the shared bit-serial divider, which runs three
//   32-step divisions back to back (step, delta seconds, smoothed delta);
//   in variable mode a 23-step shift-add multiplier replaces the first one.
//   The frame-rate division and its average run on a second divider alongside.
//   The result sits in an output register; the next item may be accepted while
//   it waits, and a stalled result only holds back the finish of the next one.
//   Reset (rst_ni low, asynchronous) restores config defaults, clears the
//   accumulator and stamps, and loads the 1/60 s delta and 60 fps averages.
//   Config writes (cfg_we_i) are taken in any cycle but belong to idle time.
`default_nettype none

module scaled_frame_timer_core #(
  parameter int FRAC_BITS    = 16,
  parameter int AVERAGE_SPAN = 60
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // config write port
  input  wire                           cfg_we_i,
  input  wire [sft_pkg::IDX_W-1:0]      cfg_index_i,
  input  wire [sft_pkg::CFG_W-1:0]      cfg_data_i,
  // input channel
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire [sft_pkg::OP_W-1:0]       opcode_i,
  input  wire [sft_pkg::TS_W-1:0]       timestamp_i,
  // output channel
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [sft_pkg::TS_W-1:0]      elapsed_ticks_o,
  output logic [sft_pkg::TS_W-1:0]      delta_ticks_o,
  output logic [sft_pkg::FX_W-1:0]      delta_seconds_o,
  output logic [sft_pkg::FX_W-1:0]      smoothed_delta_o,
  output logic [sft_pkg::FX_W-1:0]      frame_rate_o,
  output logic                          is_paused_o
);

  localparam int TW     = sft_pkg::TS_W;
  localparam int FW     = sft_pkg::FX_W;
  localparam int PR_W   = sft_pkg::PR_W;
  localparam int PROD_W = TW + PR_W;
  // blend sum: fresh + avg * (span - 1) < 2^32 * span
  localparam int SUM_W  = FW + $clog2(AVERAGE_SPAN);

  localparam logic [FW-1:0]   DEF_DELTA = FW'((64'd1 << FRAC_BITS) / 60);
  localparam logic [FW-1:0]   DEF_RATE  = FW'(64'd60 << FRAC_BITS);
  localparam logic [PR_W-1:0] PR_RESET  = PR_W'(64'd1 << FRAC_BITS);
  localparam logic [TW-1:0]   AVG_DEN   = TW'(AVERAGE_SPAN);
  localparam logic [SUM_W-1:0] AVG_KEEP = SUM_W'(AVERAGE_SPAN - 1);
  localparam logic [sft_pkg::MCNT_W-1:0] MUL_LAST = sft_pkg::MCNT_W'(PR_W - 1);

  // main sequencer
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LAUNCH  = 4'd1;
  localparam logic [3:0] S_MUL     = 4'd2;
  localparam logic [3:0] S_MULSAT  = 4'd3;
  localparam logic [3:0] S_STEPDIV = 4'd4;
  localparam logic [3:0] S_ACC     = 4'd5;
  localparam logic [3:0] S_DS      = 4'd6;
  localparam logic [3:0] S_SDGO    = 4'd7;
  localparam logic [3:0] S_SD      = 4'd8;
  localparam logic [3:0] S_JOIN    = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  // frame-rate side chain
  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_INST = 3'd1;
  localparam logic [2:0] B_SUM  = 3'd2;
  localparam logic [2:0] B_RA   = 3'd3;
  localparam logic [2:0] B_DONE = 3'd4;

  // config registers
  logic [sft_pkg::TF_W-1:0]  tick_freq_q;
  logic                      fixed_mode_q;
  logic [sft_pkg::FFR_W-1:0] fixed_rate_q;
  logic [PR_W-1:0]           play_rate_q;

  // timer state
  logic [TW-1:0] acc_q, prev_acc_q, cur_stamp_q;
  logic [FW-1:0] ds_q, sd_q, ra_q;
  logic          paused_q;

  // working registers
  logic [3:0]                 state_q;
  logic [2:0]                 b_phase_q;
  logic [sft_pkg::MCNT_W-1:0] mul_cnt_q;
  logic [TW-1:0]              interval_q, step_q;
  logic [PROD_W-1:0]          prod_q, prod_d, prod_shr;
  logic [TW:0]                mul_sum;
  logic [TW-1:0]              prod_sat;
  logic [SUM_W-1:0]           sum_a_q, sum_b_q;
  logic                       out_valid_q;

  logic                       in_acc, out_free;
  logic [sft_pkg::FFR_W-1:0]  ffr_eff;

  sft_pkg::div_ctl_t ctl_a, ctl_b;
  logic [TW-1:0]     num_a, den_a, num_b, den_b;
  logic              done_a, done_b;
  logic [FW-1:0]     quo_a, quo_b;

  function automatic logic [SUM_W-1:0] blend_sum(input logic [FW-1:0] fresh,
                                                 input logic [FW-1:0] avg);
    return SUM_W'(fresh) + SUM_W'(avg) * AVG_KEEP;
  endfunction

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  // output slot frees when empty or when its beat leaves this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign ffr_eff    = (fixed_rate_q == '0) ? sft_pkg::FFR_W'(1) : fixed_rate_q;

  // shift-add multiply of interval by play_rate, multiplier bits LSB first
  assign mul_sum  = {1'b0, prod_q[PROD_W-1:PR_W]} + (prod_q[0] ? {1'b0, interval_q} : '0);
  assign prod_d   = {mul_sum, prod_q[PR_W-1:1]};
  assign prod_shr = prod_q >> FRAC_BITS;
  assign prod_sat = (|prod_shr[PROD_W-1:TW]) ? '1 : prod_shr[TW-1:0];

  // divider A: fixed step, delta seconds, smoothed delta
  always_comb begin
    ctl_a.start = (state_q == S_LAUNCH && fixed_mode_q) || state_q == S_ACC ||
                  state_q == S_SDGO;
    ctl_a.frac  = (state_q == S_ACC);
    num_a       = TW'(tick_freq_q);
    den_a       = TW'(ffr_eff);
    if (state_q == S_ACC) begin
      num_a = step_q;
      den_a = TW'(tick_freq_q);
    end else if (state_q == S_SDGO) begin
      num_a = TW'(sum_a_q);
      den_a = AVG_DEN;
    end
  end

  // divider B: instantaneous frame rate, then its average
  always_comb begin
    ctl_b.start = (state_q == S_LAUNCH) || (b_phase_q == B_SUM);
    ctl_b.frac  = (b_phase_q != B_SUM);
    num_b       = (b_phase_q == B_SUM) ? TW'(sum_b_q) : TW'(tick_freq_q);
    den_b       = (b_phase_q == B_SUM) ? AVG_DEN : interval_q;
  end

  sft_div #(.FRAC_BITS(FRAC_BITS)) u_div_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_a),
    .num_i  (num_a),
    .den_i  (den_a),
    .done_o (done_a),
    .quo_o  (quo_a)
  );

  sft_div #(.FRAC_BITS(FRAC_BITS)) u_div_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_b),
    .num_i  (num_b),
    .den_i  (den_b),
    .done_o (done_b),
    .quo_o  (quo_b)
  );

  // config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_freq_q  <= sft_pkg::TICK_FREQ_RESET;
      fixed_mode_q <= 1'b0;
      fixed_rate_q <= sft_pkg::FIXED_RATE_RESET;
      play_rate_q  <= PR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sft_pkg::REG_TICK_FREQ:  tick_freq_q  <= cfg_data_i[sft_pkg::TF_W-1:0];
        sft_pkg::REG_FIXED_MODE: fixed_mode_q <= cfg_data_i[0];
        sft_pkg::REG_FIXED_RATE: fixed_rate_q <= cfg_data_i[sft_pkg::FFR_W-1:0];
        sft_pkg::REG_PLAY_RATE:  play_rate_q  <= cfg_data_i[PR_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      b_phase_q   <= B_IDLE;
      mul_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      prev_acc_q  <= '0;
      cur_stamp_q <= '0;
      ds_q        <= DEF_DELTA;
      sd_q        <= DEF_DELTA;
      ra_q        <= DEF_RATE;
      paused_q    <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_FIN;
            case (opcode_i)
              sft_pkg::OP_TICK: begin
                // paused ticks change nothing
                if (!paused_q) begin
                  prev_acc_q  <= acc_q;
                  cur_stamp_q <= timestamp_i;
                  state_q     <= S_LAUNCH;
                end
              end
              sft_pkg::OP_RESTART: begin
                acc_q      <= '0;
                prev_acc_q <= '0;
                sd_q       <= DEF_DELTA;
              end
              sft_pkg::OP_PAUSE: begin
                paused_q <= 1'b1;
                ds_q     <= '0;
                sd_q     <= '0;
                ra_q     <= '0;
              end
              sft_pkg::OP_RESUME: begin
                paused_q    <= 1'b0;
                cur_stamp_q <= timestamp_i;
                sd_q        <= DEF_DELTA;
                ra_q        <= DEF_RATE;
              end
              default: ;
            endcase
          end
        end
        S_LAUNCH: begin
          b_phase_q <= B_INST;
          mul_cnt_q <= '0;
          state_q   <= fixed_mode_q ? S_STEPDIV : S_MUL;
        end
        S_MUL: begin
          mul_cnt_q <= mul_cnt_q + 1'b1;
          if (mul_cnt_q == MUL_LAST) begin
            state_q <= S_MULSAT;
          end
        end
        S_MULSAT:  state_q <= S_ACC;
        S_STEPDIV: if (done_a) state_q <= S_ACC;
        S_ACC: begin
          acc_q   <= acc_q + step_q;
          state_q <= S_DS;
        end
        S_DS: begin
          if (done_a) begin
            ds_q    <= quo_a;
            state_q <= S_SDGO;
          end
        end
        S_SDGO: state_q <= S_SD;
        S_SD: begin
          if (done_a) begin
            sd_q    <= quo_a;
            state_q <= S_JOIN;
          end
        end
        S_JOIN: if (b_phase_q == B_DONE) state_q <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            b_phase_q   <= B_IDLE;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // frame-rate chain runs beside the main sequence
      case (b_phase_q)
        B_INST: if (done_b) b_phase_q <= B_SUM;
        B_SUM:  b_phase_q <= B_RA;
        B_RA: begin
          if (done_b) begin
            ra_q      <= quo_b;
            b_phase_q <= B_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      interval_q <= timestamp_i - cur_stamp_q;
    end
    if (state_q == S_LAUNCH) begin
      prod_q <= {{TW{1'b0}}, play_rate_q};
    end else if (state_q == S_MUL) begin
      prod_q <= prod_d;
    end
    if (state_q == S_MULSAT) begin
      step_q <= prod_sat;
    end else if (state_q == S_STEPDIV && done_a) begin
      step_q <= TW'(quo_a);
    end
    if (state_q == S_DS && done_a) begin
      sum_a_q <= blend_sum(quo_a, sd_q);
    end
    if (b_phase_q == B_INST && done_b) begin
      sum_b_q <= blend_sum(quo_b, ra_q);
    end
    if (state_q == S_FIN && out_free) begin
      elapsed_ticks_o  <= acc_q;
      delta_ticks_o    <= paused_q ? '0 : acc_q - prev_acc_q;
      delta_seconds_o  <= ds_q;
      smoothed_delta_o <= sd_q;
      frame_rate_o     <= ra_q;
      is_paused_o      <= paused_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // one item in flight: an accepted beat always blocks the next cycle
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while an item is in flight");

  // the frame-rate chain is idle whenever the block can take a beat
  a_chain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (b_phase_q == B_IDLE))
    else $error("frame-rate chain busy at idle");

  // a paused result reports zero delta, delta seconds and frame rate
  a_paused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_paused_o) |->
      (delta_ticks_o == '0 && delta_seconds_o == '0 && frame_rate_o == '0))
    else $error("paused result with nonzero timing fields");
`endif

endmodule

`default_nettype wire
